// ===== hw/rtl/dqpi_pkg.sv =====
// Shared types, constants and arithmetic helpers for the dq current PI controller.
`timescale 1ns / 1ps

package dqpi_pkg;

	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 24;
	localparam int CurW       = 16;
	localparam int VbusW      = 17;
	localparam int AudioW     = 18;
	localparam int VoutW      = 18;
	localparam int IntegW     = 24;
	localparam int AccelW     = 15;
	localparam int KpW        = 24;
	localparam int KiW        = 16;
	localparam int VlimW      = 17;
	localparam int MulAW      = 25;
	localparam int MulBW      = 18;
	localparam int ProdW      = MulAW + MulBW;
	localparam int RndW       = ProdW - 15;
	localparam int RadW       = 34;
	localparam int RootW      = RadW / 2;
	localparam int RemW       = RootW + 2;
	localparam int SqrtSteps  = RootW;
	localparam int SqrtCntW   = $clog2(SqrtSteps);

	localparam logic [15:0]       VbusScale = 16'd62259;
	localparam logic [AccelW-1:0] AccelRst  = 15'd32767;
	localparam logic [KpW-1:0]    KpRst     = 24'd65536;
	localparam logic [KiW-1:0]    KiRst     = 16'd0;
	localparam logic [VlimW-1:0]  VlimRst   = 17'd131071;

	// register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] RegAccel = 2'd0;
	localparam logic [CfgIdxW-1:0] RegKp    = 2'd1;
	localparam logic [CfgIdxW-1:0] RegKi    = 2'd2;
	localparam logic [CfgIdxW-1:0] RegVlim  = 2'd3;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_PD,
		OP_MUL_PQ,
		OP_MUL_VB,
		OP_VDMAX,
		OP_CLAMP_D,
		OP_SQ_MAX,
		OP_SQ_VD,
		OP_RAD,
		OP_SQRT_STEP,
		OP_CLAMP_Q,
		OP_DIFF,
		OP_MUL_ID,
		OP_MUL_IQ,
		OP_FINISH
	} dqpi_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_PD,
		ST_MUL_PQ,
		ST_MUL_VB,
		ST_VDMAX,
		ST_CLAMP_D,
		ST_SQ_MAX,
		ST_SQ_VD,
		ST_RAD,
		ST_SQRT,
		ST_CLAMP_Q,
		ST_DIFF,
		ST_MUL_ID,
		ST_MUL_IQ,
		ST_FINISH
	} dqpi_state_t;

	typedef struct packed {
		dqpi_op_t op;
	} dqpi_cmd_t;

	typedef struct packed {
		logic out_free;
	} dqpi_stat_t;

	// Q16 round to nearest, ties toward plus infinity
	function automatic logic signed [RndW-1:0] rnd_q16(input logic signed [ProdW-1:0] x);
		logic signed [ProdW:0] t;
		t = {x[ProdW-1], x} + (ProdW+1)'(32768);
		return t[ProdW:16];
	endfunction

	// integrator plus rounded step, saturated to the integrator width
	function automatic logic signed [IntegW-1:0] integ_next(
		input logic signed [IntegW-1:0] acc,
		input logic signed [RndW-1:0]   step
	);
		logic signed [RndW:0] sum;
		sum = {step[RndW-1], step} + (RndW+1)'(acc);
		if (sum > (RndW+1)'(signed'(24'sh7FFFFF)))
			return 24'sh7FFFFF;
		else if (sum < (RndW+1)'(signed'(24'sh800000)))
			return 24'sh800000;
		else
			return sum[IntegW-1:0];
	endfunction

endpackage

// ===== hw/rtl/dqpi_ctrl.sv =====
// Sequencer for the dq current PI controller: walks the datapath through one update.
`timescale 1ns / 1ps

module dqpi_ctrl
	import dqpi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dqpi_stat_t stat,
	output dqpi_cmd_t  cmd
);

	dqpi_state_t         state_q, state_d;
	logic [SqrtCntW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SQRT)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_MUL_PD;
			ST_MUL_PD:  state_d = ST_MUL_PQ;
			ST_MUL_PQ:  state_d = ST_MUL_VB;
			ST_MUL_VB:  state_d = ST_VDMAX;
			ST_VDMAX:   state_d = ST_CLAMP_D;
			ST_CLAMP_D: state_d = ST_SQ_MAX;
			ST_SQ_MAX:  state_d = ST_SQ_VD;
			ST_SQ_VD:   state_d = ST_RAD;
			ST_RAD:     state_d = ST_SQRT;
			ST_SQRT:    if (cnt_q == SqrtCntW'(SqrtSteps - 1)) state_d = ST_CLAMP_Q;
			ST_CLAMP_Q: state_d = ST_DIFF;
			ST_DIFF:    state_d = ST_MUL_ID;
			ST_MUL_ID:  state_d = ST_MUL_IQ;
			ST_MUL_IQ:  state_d = ST_FINISH;
			ST_FINISH:  if (stat.out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_MUL_PD:  cmd.op = OP_MUL_PD;
			ST_MUL_PQ:  cmd.op = OP_MUL_PQ;
			ST_MUL_VB:  cmd.op = OP_MUL_VB;
			ST_VDMAX:   cmd.op = OP_VDMAX;
			ST_CLAMP_D: cmd.op = OP_CLAMP_D;
			ST_SQ_MAX:  cmd.op = OP_SQ_MAX;
			ST_SQ_VD:   cmd.op = OP_SQ_VD;
			ST_RAD:     cmd.op = OP_RAD;
			ST_SQRT:    cmd.op = OP_SQRT_STEP;
			ST_CLAMP_Q: cmd.op = OP_CLAMP_Q;
			ST_DIFF:    cmd.op = OP_DIFF;
			ST_MUL_ID:  cmd.op = OP_MUL_ID;
			ST_MUL_IQ:  cmd.op = OP_MUL_IQ;
			ST_FINISH:  if (stat.out_free) cmd.op = OP_FINISH;
			default:    cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== hw/rtl/dqpi_datapath.sv =====
// Datapath: config registers, shared multiplier, limiters, square root and integrators.
`timescale 1ns / 1ps

module dqpi_datapath
	import dqpi_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  dqpi_cmd_t                cmd,
	output dqpi_stat_t               stat,
	input  logic                     cfg_valid,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [CfgDataW-1:0]      cfg_data,
	input  logic signed [CurW-1:0]   id_ma,
	input  logic signed [CurW-1:0]   iq_ma,
	input  logic signed [CurW-1:0]   setpoint_ma,
	input  logic [VbusW-1:0]         vbus_mv,
	input  logic signed [AudioW-1:0] audio_mv,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [VoutW-1:0]  vd_mv,
	output logic signed [VoutW-1:0]  vq_mv
);

	// configuration
	logic [AccelW-1:0] accel_q;
	logic [KpW-1:0]    kp_q;
	logic [KiW-1:0]    ki_q;
	logic [VlimW-1:0]  vlim_q;

	// state
	logic signed [IntegW-1:0] integ_d_q, integ_q_q;
	logic                     out_valid_q;

	// working registers
	logic signed [CurW:0]     ed_q;
	logic signed [CurW-1:0]   eq_q;
	logic [VbusW-1:0]         vbus_q;
	logic signed [AudioW-1:0] audio_q;
	logic signed [ProdW-1:0]  prod_q;
	logic signed [RndW-1:0]   vd_raw_q, vq_raw_q;
	logic [VlimW-1:0]         vdmax_q;
	logic signed [VoutW-1:0]  vd_q, vq_q;
	logic [RadW-1:0]          sq_q;
	logic [RemW-1:0]          rem_q;
	logic [RootW-1:0]         root_q;
	logic signed [MulAW-1:0]  diff_d_q, diff_q_q;
	logic signed [VoutW-1:0]  vd_out_q, vq_out_q;

	logic signed [MulAW-1:0] mul_a;
	logic signed [MulBW-1:0] mul_b;
	logic signed [ProdW-1:0] mul_p;
	logic signed [RndW-1:0]  prod_rnd;

	logic signed [CurW:0]    err_q_raw;
	logic signed [CurW:0]    lim_s;
	logic signed [CurW:0]    lim_n;
	logic signed [CurW-1:0]  err_q_clamped;

	logic [RemW+1:0]         trial;
	logic [RemW+1:0]         trial_sub;

	logic signed [RndW-1:0]  vmax_s, rmax_s;
	logic [VlimW-1:0]        vbus_scaled;

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign vd_mv         = vd_out_q;
	assign vq_mv         = vq_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= AccelRst;
			kp_q    <= KpRst;
			ki_q    <= KiRst;
			vlim_q  <= VlimRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegAccel: accel_q <= cfg_data[AccelW-1:0];
				RegKp:    kp_q    <= cfg_data[KpW-1:0];
				RegKi:    ki_q    <= cfg_data[KiW-1:0];
				RegVlim:  vlim_q  <= cfg_data[VlimW-1:0];
				default:  ;
			endcase
		end
	end

	// q error limited to the acceleration current
	always_comb begin
		err_q_raw = (CurW+1)'(setpoint_ma) - (CurW+1)'(iq_ma);
		lim_s     = signed'({2'b00, accel_q});
		lim_n     = -lim_s;
		if (err_q_raw > lim_s)
			err_q_clamped = lim_s[CurW-1:0];
		else if (err_q_raw < lim_n)
			err_q_clamped = lim_n[CurW-1:0];
		else
			err_q_clamped = err_q_raw[CurW-1:0];
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MUL_PD: begin
				mul_a = signed'({1'b0, kp_q});
				mul_b = MulBW'(ed_q);
			end
			OP_MUL_PQ: begin
				mul_a = signed'({1'b0, kp_q});
				mul_b = MulBW'(eq_q);
			end
			OP_MUL_VB: begin
				mul_a = signed'(MulAW'(vbus_q));
				mul_b = signed'(MulBW'(VbusScale));
			end
			OP_SQ_MAX: begin
				mul_a = signed'(MulAW'(vdmax_q));
				mul_b = signed'(MulBW'(vdmax_q));
			end
			OP_SQ_VD: begin
				mul_a = MulAW'(vd_q);
				mul_b = vd_q;
			end
			OP_MUL_ID: begin
				mul_a = diff_d_q;
				mul_b = signed'(MulBW'(ki_q));
			end
			OP_MUL_IQ: begin
				mul_a = diff_q_q;
				mul_b = signed'(MulBW'(ki_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign prod_rnd = rnd_q16(prod_q);

	assign vbus_scaled = prod_q[VlimW+15:16];
	assign vmax_s      = signed'(RndW'(vdmax_q));
	assign rmax_s      = signed'(RndW'(root_q));

	// one root bit per step
	assign trial     = {rem_q, sq_q[RadW-1 -: 2]};
	assign trial_sub = (RemW+2)'({root_q, 2'b01});

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				ed_q    <= -(CurW+1)'(id_ma);
				eq_q    <= err_q_clamped;
				vbus_q  <= vbus_mv;
				audio_q <= audio_mv;
			end
			OP_MUL_PD: prod_q <= mul_p;
			OP_MUL_PQ: begin
				vd_raw_q <= prod_rnd + RndW'(integ_d_q);
				prod_q   <= mul_p;
			end
			OP_MUL_VB: begin
				vq_raw_q <= prod_rnd + RndW'(integ_q_q) + RndW'(audio_q);
				prod_q   <= mul_p;
			end
			OP_VDMAX: vdmax_q <= (vlim_q < vbus_scaled) ? vlim_q : vbus_scaled;
			OP_CLAMP_D: begin
				if (vd_raw_q > vmax_s)
					vd_q <= vmax_s[VoutW-1:0];
				else if (vd_raw_q < -vmax_s)
					vd_q <= VoutW'(-vmax_s);
				else
					vd_q <= vd_raw_q[VoutW-1:0];
			end
			OP_SQ_MAX: prod_q <= mul_p;
			OP_SQ_VD: begin
				sq_q   <= prod_q[RadW-1:0];
				prod_q <= mul_p;
			end
			OP_RAD: begin
				sq_q   <= sq_q - prod_q[RadW-1:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_SQRT_STEP: begin
				sq_q <= {sq_q[RadW-3:0], 2'b00};
				if (trial >= trial_sub) begin
					rem_q  <= RemW'(trial - trial_sub);
					root_q <= {root_q[RootW-2:0], 1'b1};
				end else begin
					rem_q  <= trial[RemW-1:0];
					root_q <= {root_q[RootW-2:0], 1'b0};
				end
			end
			OP_CLAMP_Q: begin
				if (vq_raw_q > rmax_s)
					vq_q <= rmax_s[VoutW-1:0];
				else if (vq_raw_q < -rmax_s)
					vq_q <= VoutW'(-rmax_s);
				else
					vq_q <= vq_raw_q[VoutW-1:0];
			end
			OP_DIFF: begin
				diff_d_q <= MulAW'(vd_q) - MulAW'(integ_d_q);
				diff_q_q <= MulAW'(vq_q) - MulAW'(integ_q_q);
			end
			OP_MUL_ID: prod_q <= mul_p;
			OP_MUL_IQ: prod_q <= mul_p;
			OP_FINISH: begin
				vd_out_q <= vd_q;
				vq_out_q <= vq_q;
			end
			default: ;
		endcase
	end

	// integrators and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_d_q   <= '0;
			integ_q_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_MUL_IQ)
				integ_d_q <= integ_next(integ_d_q, prod_rnd);
			if (cmd.op == OP_FINISH) begin
				integ_q_q   <= integ_next(integ_q_q, prod_rnd);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/dq_current_pi_antiwindup.sv =====
// dq current PI controller with anti-windup. A new request is accepted only once the previous
// one has finished; each update steps through products on the one shared multiplier, limiters
// and the bit-serial square root of the q limit.
// A waiting result stays in the output register until taken; the next update holds at its end.
// Reset (arst_n low, asynchronous) zeroes both integrators, clears the result flag and loads
// the configuration register reset values.
`timescale 1ns / 1ps

module dq_current_pi_antiwindup
	import dqpi_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [CfgDataW-1:0]      cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CurW-1:0]   id_ma,
	input  logic signed [CurW-1:0]   iq_ma,
	input  logic signed [CurW-1:0]   setpoint_ma,
	input  logic [VbusW-1:0]         vbus_mv,
	input  logic signed [AudioW-1:0] audio_mv,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [VoutW-1:0]  vd_mv,
	output logic signed [VoutW-1:0]  vq_mv
);

	dqpi_cmd_t  cmd;
	dqpi_stat_t stat;

	assign cfg_ready = 1'b1;

	dqpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dqpi_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.id_ma       (id_ma),
		.iq_ma       (iq_ma),
		.setpoint_ma (setpoint_ma),
		.vbus_mv     (vbus_mv),
		.audio_mv    (audio_mv),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.vd_mv       (vd_mv),
		.vq_mv       (vq_mv)
	);

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the dq current PI controller with anti-windup.
`timescale 1ns / 1ps

module tb;
	import dqpi_pkg::*;

	localparam int WatchdogLimit = 2000;
	localparam int StallCycles   = 300;
	localparam int MaxReported   = 10;
	localparam int TailCycles    = 40;
	localparam longint IntegMax  = (longint'(1) <<< (IntegW - 1)) - 1;
	localparam longint IntegMin  = -(longint'(1) <<< (IntegW - 1));

	typedef struct packed {
		logic signed [CurW-1:0]   id;
		logic signed [CurW-1:0]   iq;
		logic signed [CurW-1:0]   sp;
		logic [VbusW-1:0]         vbus;
		logic signed [AudioW-1:0] audio;
	} dq_sample_t;

	typedef struct packed {
		logic signed [VoutW-1:0] vd;
		logic signed [VoutW-1:0] vq;
	} dq_volts_t;

	logic                     clk;
	logic                     arst_n      = 1'b0;
	logic                     cfg_valid   = 1'b0;
	logic                     cfg_ready;
	logic [CfgIdxW-1:0]       cfg_index   = '0;
	logic [CfgDataW-1:0]      cfg_data    = '0;
	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic signed [CurW-1:0]   id_ma       = '0;
	logic signed [CurW-1:0]   iq_ma       = '0;
	logic signed [CurW-1:0]   setpoint_ma = '0;
	logic [VbusW-1:0]         vbus_mv     = '0;
	logic signed [AudioW-1:0] audio_mv    = '0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic signed [VoutW-1:0]  vd_mv;
	logic signed [VoutW-1:0]  vq_mv;

	// predictor copy of the registers and integrators
	logic [AccelW-1:0] accel_lim  = AccelRst;
	logic [KpW-1:0]    kp_gain    = KpRst;
	logic [KiW-1:0]    ki_gain    = KiRst;
	logic [VlimW-1:0]  volt_lim   = VlimRst;
	longint            integ_d_mv = 0;
	longint            integ_q_mv = 0;

	dq_volts_t pending_volts[$];
	int        mismatches    = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        stall_req     = 0;
	int        stall_ack     = 0;
	int        stall_left    = 0;
	int        quiet_cycles  = 0;

	dq_current_pi_antiwindup dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.id_ma      (id_ma),
		.iq_ma      (iq_ma),
		.setpoint_ma(setpoint_ma),
		.vbus_mv    (vbus_mv),
		.audio_mv   (audio_mv),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.vd_mv      (vd_mv),
		.vq_mv      (vq_mv)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// round to nearest in Q16, ties upward
	function automatic longint q16_round(input longint x);
		return (x + 32768) >>> 16;
	endfunction

	function automatic longint root_floor(input longint n);
		longint r;
		longint b;
		r = 0;
		b = longint'(1) <<< 62;
		while (b > n)
			b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - r - b;
				r = (r >>> 1) + b;
			end else
				r = r >>> 1;
			b = b >>> 2;
		end
		return r;
	endfunction

	// voltages for one sample; advances the integrators
	function automatic dq_volts_t predict_voltages(input dq_sample_t s);
		longint    ed, eq, vd, vq, vdmax, vqmax, bus_cap, lim;
		dq_volts_t v;
		lim = longint'(accel_lim);
		ed = -longint'(signed'(s.id));
		eq = clip(longint'(signed'(s.sp)) - longint'(signed'(s.iq)), -lim, lim);
		vd = q16_round(longint'(kp_gain) * ed) + integ_d_mv;
		vq = q16_round(longint'(kp_gain) * eq) + integ_q_mv + longint'(signed'(s.audio));
		bus_cap = (longint'(s.vbus) * longint'(VbusScale)) >>> 16;
		vdmax = (longint'(volt_lim) < bus_cap) ? longint'(volt_lim) : bus_cap;
		vd = clip(vd, -vdmax, vdmax);
		vqmax = root_floor(vdmax * vdmax - vd * vd);
		vq = clip(vq, -vqmax, vqmax);
		integ_d_mv = clip(integ_d_mv + q16_round(longint'(ki_gain) * (vd - integ_d_mv)),
			IntegMin, IntegMax);
		integ_q_mv = clip(integ_q_mv + q16_round(longint'(ki_gain) * (vq - integ_q_mv)),
			IntegMin, IntegMax);
		v.vd = vd[VoutW-1:0];
		v.vq = vq[VoutW-1:0];
		return v;
	endfunction

	function automatic dq_sample_t sample_of(input int id, input int iq, input int sp,
		input int vbus, input int audio);
		dq_sample_t s;
		s.id    = CurW'(id);
		s.iq    = CurW'(iq);
		s.sp    = CurW'(sp);
		s.vbus  = VbusW'(vbus);
		s.audio = AudioW'(audio);
		return s;
	endfunction

	function automatic logic signed [CurW-1:0] pick_current(input logic signed [CurW-1:0] centre);
		case ($urandom_range(9))
		0: return -16'sd32768;
		1: return 16'sd32767;
		2, 3: return CurW'($urandom);
		default: return centre + CurW'($urandom_range(400)) - 16'sd200;
		endcase
	endfunction

	// mostly a tracking loop around the setpoint, the rest pure noise
	function automatic dq_sample_t rand_sample(input logic signed [CurW-1:0] sp_now);
		dq_sample_t s;
		if ($urandom_range(4) == 0) begin
			s.id    = CurW'($urandom);
			s.iq    = CurW'($urandom);
			s.sp    = CurW'($urandom);
			s.vbus  = VbusW'($urandom);
			s.audio = AudioW'($urandom);
		end else begin
			s.sp = sp_now;
			s.iq = pick_current(sp_now);
			s.id = pick_current(16'sd0);
			case ($urandom_range(9))
			0: s.vbus = '0;
			1: s.vbus = '1;
			default: s.vbus = VbusW'($urandom_range(131071, 12000));
			endcase
			case ($urandom_range(9))
			0: s.audio = -18'sd131072;
			1: s.audio = 18'sd131071;
			2: s.audio = AudioW'($urandom);
			default: s.audio = AudioW'($urandom_range(6000)) - 18'sd3000;
			endcase
		end
		return s;
	endfunction

	function automatic int unsigned pick_limit(input int unsigned hi);
		case ($urandom_range(7))
		0: return 0;
		1: return hi;
		default: return $urandom_range(hi);
		endcase
	endfunction

	function automatic int unsigned pick_kp();
		case ($urandom_range(7))
		0: return 0;
		1: return 24'hFFFFFF;
		2, 3: return $urandom_range(1 << 20);
		default: return $urandom_range(1 << 18);
		endcase
	endfunction

	// one request on the input channel; leaves valid high for the next one
	task automatic send_sample(input dq_sample_t s);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		id_ma       <= s.id;
		iq_ma       <= s.iq;
		setpoint_ma <= s.sp;
		vbus_mv     <= s.vbus;
		audio_mv    <= s.audio;
		in_valid    <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		pending_volts.push_back(predict_voltages(s));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_volts.size() != 0)
			@(posedge clk);
	endtask

	// unused high bits of the write data carry junk
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
		logic [CfgDataW-1:0] data;
		data = CfgDataW'($urandom);
		case (idx)
		RegAccel: data[AccelW-1:0] = value[AccelW-1:0];
		RegKp:    data[KpW-1:0]    = value[KpW-1:0];
		RegKi:    data[KiW-1:0]    = value[KiW-1:0];
		RegVlim:  data[VlimW-1:0]  = value[VlimW-1:0];
		endcase
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
		RegAccel: accel_lim = data[AccelW-1:0];
		RegKp:    kp_gain   = data[KpW-1:0];
		RegKi:    ki_gain   = data[KiW-1:0];
		RegVlim:  volt_lim  = data[VlimW-1:0];
		endcase
	endtask

	task automatic configure(input int unsigned accel, input int unsigned kp,
		input int unsigned ki, input int unsigned vlim);
		drain();
		write_reg(RegAccel, accel);
		write_reg(RegKp, kp);
		write_reg(RegKi, ki);
		write_reg(RegVlim, vlim);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_values();
		send_sample(sample_of(0, 0, 0, 0, 0));
		send_sample(sample_of(-32768, -32768, 32767, 131071, 131071));
		send_sample(sample_of(32767, 32767, -32768, 131071, -131072));
		send_sample(sample_of(100, -200, 300, 48000, 0));
	endtask

	task automatic test_directed();
		configure(1000, 3 * 65536, 8192, 50000);
		send_sample(sample_of(0, -32768, 32767, 131071, 0));
		send_sample(sample_of(0, 32767, -32768, 131071, 0));
		send_sample(sample_of(-500, 100, 600, 100000, 2000));
		send_sample(sample_of(0, 0, 0, 131071, 131071));
		send_sample(sample_of(0, 0, 0, 131071, -131072));
		send_sample(sample_of(1000, 0, 500, 0, 500));
		send_sample(sample_of(-1000, 0, 500, 1, 0));
		// zero voltage limit: outputs pinned at zero, integrators bleed off
		configure(32767, 65536, 65535, 0);
		send_sample(sample_of(-30000, 0, 30000, 131071, 100000));
		send_sample(sample_of(30000, 5000, -5000, 131071, -100000));
		send_sample(sample_of(0, 0, 0, 131071, 0));
		configure(0, 24'hFFFFFF, 65535, 131071);
		send_sample(sample_of(-32768, 5, -5, 131071, 0));
		send_sample(sample_of(32767, -5, 5, 131071, 0));
		send_sample(sample_of(1, 0, 0, 131071, -3));
		configure(32767, 0, 0, 131071);
		send_sample(sample_of(12345, -2000, 2000, 70000, -50000));
		send_sample(sample_of(0, 0, 0, 131071, 0));
	endtask

	task automatic test_random(input int n_items, input int s_idle, input int r_idle);
		logic signed [CurW-1:0] sp_now;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		sp_now = '0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 150 == 0)
				configure(pick_limit(32767), pick_kp(), pick_limit(65535), pick_limit(131071));
			if (i % 40 == 0)
				sp_now = CurW'($urandom_range(20000)) - 16'sd10000;
			send_sample(rand_sample(sp_now));
		end
	endtask

	// long hold-off on the result side while requests keep coming
	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_req = stall_req + 1;
		for (int i = 0; i < 30; i++)
			send_sample(rand_sample(16'sd1500));
	endtask

	always @(posedge clk) begin
		if (stall_req != stall_ack) begin
			stall_ack  = stall_req;
			stall_left = StallCycles;
		end
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : check_volts
		dq_volts_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_volts.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReported)
					$display("result vd=%0d vq=%0d with no request outstanding", vd_mv, vq_mv);
			end else begin
				want = pending_volts.pop_front();
				if (vd_mv !== want.vd || vq_mv !== want.vq) begin
					mismatches++;
					if (mismatches <= MaxReported)
						$display("voltage mismatch: expected vd=%0d vq=%0d, got vd=%0d vq=%0d",
							want.vd, want.vq, vd_mv, vq_mv);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WatchdogLimit) begin
			$display("CHECK FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 28;
		recv_idle_pct = 61;
		test_reset_values();
		test_directed();
		test_random(500, 28, 61);
		test_random(500, 61, 28);
		test_random(450, 0, 0);
		test_output_stall();
		drain();
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0 && pending_volts.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
